FILE: rtl/tfc_pkg.sv
package tfc_pkg;

  // Delimiter characters that split tokens.
  localparam logic [7:0] CHAR_PERIOD   = 8'h2E;
  localparam logic [7:0] CHAR_COMMA    = 8'h2C;
  localparam logic [7:0] CHAR_EXCLAIM  = 8'h21;
  localparam logic [7:0] CHAR_QUESTION = 8'h3F;
  localparam logic [7:0] CHAR_SPACE    = 8'h20;

  // Payload widths fixed by the stream format.
  localparam int IN_BYTES  = 1;
  localparam int OUT_BYTES = 5;

  function automatic logic is_delim(input logic [7:0] c);
    return (c == CHAR_PERIOD) || (c == CHAR_COMMA) || (c == CHAR_EXCLAIM) ||
           (c == CHAR_QUESTION) || (c == CHAR_SPACE);
  endfunction

endpackage

FILE: rtl/tfc_cell.sv
module tfc_cell import tfc_pkg::*; #(
  parameter int MAX_CHARS  = 32,
  parameter int COUNT_BITS = 16,
  parameter int LEN_BITS   = 6
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  step,
  input  logic                  add,
  input  logic [7:0]            ch,
  input  logic [LEN_BITS-1:0]   pos,
  input  logic [LEN_BITS-1:0]   tok_len,
  input  logic                  finish,
  input  logic                  clear_all,
  input  logic                  reset_match,
  input  logic                  alloc_in,
  input  logic                  hit_in,
  output logic                  alloc_out,
  output logic                  hit_out,
  output logic                  hit_here,
  output logic [COUNT_BITS-1:0] count_next_o
);

  localparam int CH_BITS = (MAX_CHARS > 1) ? $clog2(MAX_CHARS) : 1;

  logic                  used;
  logic                  matching;
  logic [LEN_BITS-1:0]   len;
  logic [COUNT_BITS-1:0] count;
  logic [7:0]            chars [MAX_CHARS];
  logic                  char_ok;
  logic                  alloc_here;
  logic [COUNT_BITS-1:0] count_next;

  // Per-byte compare against this cell's stored token.
  assign char_ok = used && (len > pos) && (chars[pos[CH_BITS-1:0]] == ch);

  // Priority chain: first matching cell claims the hit, first free cell the slot.
  // A byte added in the finishing cycle must also match here.
  assign hit_here   = finish && !hit_in && used && matching && (!add || char_ok) &&
                      (len == tok_len);
  assign hit_out    = hit_in || hit_here;
  assign alloc_here = finish && alloc_in && !used;
  assign alloc_out  = alloc_in && used;
  assign count_next = (&count) ? count : count + COUNT_BITS'(1);
  assign count_next_o = alloc_here ? {{(COUNT_BITS-1){1'b0}}, 1'b1} : count_next;

  always_ff @(posedge clk) begin
    if (rst || (step && clear_all)) begin
      used     <= 1'b0;
      matching <= 1'b1;
      count    <= '0;
    end else if (step) begin
      if (hit_here) begin
        count <= count_next;
      end
      if (alloc_here) begin
        used  <= 1'b1;
        len   <= tok_len;
        count <= {{(COUNT_BITS-1){1'b0}}, 1'b1};
      end
      if (reset_match) begin
        matching <= 1'b1;
      end else if (add && !char_ok) begin
        matching <= 1'b0;
      end
    end
  end

  // The first free cell collects the pending token's text as it arrives.
  always_ff @(posedge clk) begin
    if (add && step && !used && alloc_in) begin
      chars[pos[CH_BITS-1:0]] <= ch;
    end
  end

endmodule

FILE: rtl/token_frequency_counter_core.sv
// Channel | Dir | tdata fields (low bit up)                           | tlast
// s_axis  | in  | text_byte[7:0]                                      | end_of_text
// m_axis  | out | token_valid, token_index[5:0], token_count[15:0],   | text_done
//         |     | is_new, distinct_total[6:0], length_overflow,       |
//         |     | table_full (33 bits, zero filled to 40)             |
// One byte request is taken per cycle; every table cell compares the byte at
// once and the hit and free-slot search ripples along the cell chain in the
// same cycle. The result is registered and is offered the cycle after the byte.
// Reset is synchronous and clears the table, counts and pending token.
// A stall on the output holds s_tready low only while the output stage is full
// and not being drained.
module token_frequency_counter_core import tfc_pkg::*; #(
  parameter int MAX_TOKENS = 64,
  parameter int MAX_CHARS  = 32,
  parameter int COUNT_BITS = 16
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_tvalid,
  output logic                   s_tready,
  input  logic [8*IN_BYTES-1:0]  s_tdata,   // text_byte[7:0]
  input  logic                   s_tlast,   // end_of_text
  output logic                   m_tvalid,
  input  logic                   m_tready,
  output logic [8*OUT_BYTES-1:0] m_tdata,   // token_valid, token_index, token_count,
                                            // is_new, distinct_total, length_overflow,
                                            // table_full
  output logic                   m_tlast    // text_done
);

  localparam int LEN_BITS = $clog2(MAX_CHARS + 1);
  localparam int IDX_BITS = $clog2(MAX_TOKENS);
  localparam int TOT_BITS = $clog2(MAX_TOKENS + 1);

  logic [7:0]          ch;
  logic                step, delim, add, finish, pend;
  logic [LEN_BITS-1:0] cur_len;
  logic                trunc;
  logic [TOT_BITS-1:0] distinct;
  logic [MAX_TOKENS:0] alloc_c, hit_c;
  logic [MAX_TOKENS-1:0] hit_v;
  logic [COUNT_BITS-1:0] cnt_v [MAX_TOKENS];
  logic [LEN_BITS-1:0] pos;
  logic                overflow_now;

  assign ch     = s_tdata[7:0];
  assign s_tready = !m_tvalid || m_tready;
  assign step   = s_tvalid && s_tready;
  assign delim  = is_delim(ch);
  assign overflow_now = !delim && (cur_len == LEN_BITS'(MAX_CHARS));
  assign add    = !delim && !overflow_now;
  assign pos    = cur_len + (add ? LEN_BITS'(1) : LEN_BITS'(0));
  assign pend   = (pos != '0) || trunc || overflow_now;
  assign finish = (delim || s_tlast) && pend;

  assign alloc_c[0] = 1'b1;
  assign hit_c[0]   = 1'b0;

  // Chain of table cells: hit and free-slot tokens ripple from cell 0 upward.
  for (genvar i = 0; i < MAX_TOKENS; i++) begin : g_cell
    tfc_cell #(.MAX_CHARS(MAX_CHARS), .COUNT_BITS(COUNT_BITS), .LEN_BITS(LEN_BITS)) u_cell (
      .clk, .rst, .step,
      .add         (add),
      .ch          (ch),
      .pos         (cur_len),
      .tok_len     (pos),
      .finish      (finish),
      .clear_all   (s_tlast),
      .reset_match (finish),
      .alloc_in    (alloc_c[i] && !hit_c[MAX_TOKENS]),
      .hit_in      (hit_c[i]),
      .alloc_out   (alloc_c[i+1]),
      .hit_out     (hit_c[i+1]),
      .hit_here    (hit_v[i]),
      .count_next_o(cnt_v[i])
    );
  end

  // Pending token length, truncation and distinct-token count.
  always_ff @(posedge clk) begin
    if (rst) begin
      cur_len  <= '0;
      trunc    <= 1'b0;
      distinct <= '0;
    end else if (step) begin
      if (finish || s_tlast) begin
        cur_len <= '0;
        trunc   <= 1'b0;
      end else begin
        cur_len <= pos;
        trunc   <= trunc || overflow_now;
      end
      if (s_tlast) begin
        distinct <= '0;
      end else if (finish && !hit_c[MAX_TOKENS] && distinct != TOT_BITS'(MAX_TOKENS)) begin
        distinct <= distinct + TOT_BITS'(1);
      end
    end
  end

  // Result selection: the hit cell, the newly allocated one, or the table-full flag.
  logic [IDX_BITS-1:0]   r_idx;
  logic [COUNT_BITS-1:0] r_cnt;
  logic                  r_new, r_full;
  logic [TOT_BITS-1:0]   r_tot;
  always_comb begin
    r_idx = '0;
    r_cnt = '0;
    r_new = 1'b0;
    r_full = 1'b0;
    r_tot = distinct;
    if (finish) begin
      if (hit_c[MAX_TOKENS]) begin
        for (int i = 0; i < MAX_TOKENS; i++) begin
          if (hit_v[i]) begin
            r_idx = IDX_BITS'(i);
            r_cnt = cnt_v[i];
          end
        end
      end else if (!alloc_c[MAX_TOKENS]) begin
        r_idx = distinct[IDX_BITS-1:0];
        r_cnt = {{(COUNT_BITS-1){1'b0}}, 1'b1};
        r_new = 1'b1;
        r_tot = distinct + TOT_BITS'(1);
      end else begin
        r_new  = 1'b1;
        r_full = 1'b1;
      end
    end
  end

  // Output register stage.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (s_tready) begin
      m_tvalid <= step && (finish || s_tlast);
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      m_tdata <= {{(8*OUT_BYTES-33){1'b0}}, r_full, finish && (trunc || overflow_now),
                  7'(r_tot), r_new, 16'(r_cnt), 6'(r_idx), finish};
      m_tlast <= s_tlast;
    end
  end

endmodule
